/* rtl/core/prmt_pkg.sv */
// Package for the page reference-count tracker.
// Holds field widths, request and status codes, defaults and the result item type.
// No dependencies; every other file of the block but prmt_cmd_fifo uses it.
package prmt_pkg;

  // Field widths fixed by the request and result formats
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 24;
  localparam int FIRST_W    = 12;
  localparam int RUN_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 16;
  localparam int PAGE_SHIFT = 12;

  // Defaults for the top-level parameters and the command queue depth
  localparam int PAGE_COUNT_DEF     = 4096;
  localparam int MAX_SPAN_PAGES_DEF = 126;
  localparam int CMD_DEPTH          = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;
  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h4000_0000;

  // Request kinds (also the map / unmap code of a run)
  localparam logic REQ_USE     = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Status codes of the final item
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

  // One result item
  typedef struct packed {
    logic                is_request;
    logic                request_kind;
    logic [FIRST_W-1:0]  first_page;
    logic [RUN_W-1:0]    page_count;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_item_t;

endpackage

/* rtl/core/prmt_if.sv */
// Channel interfaces of the page reference-count tracker: request in, result out.
// Each carries valid, ready and the payload fields. Depends on prmt_pkg.
interface prmt_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [prmt_pkg::ADDR_W-1:0] address;
  logic [prmt_pkg::LEN_W-1:0]  byte_length;

  modport source (output valid, req_type, address, byte_length, input ready);
  modport sink   (input valid, req_type, address, byte_length, output ready);
endinterface

interface prmt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          is_request;
  logic                          request_kind;
  logic [prmt_pkg::FIRST_W-1:0]  first_page;
  logic [prmt_pkg::RUN_W-1:0]    page_count;
  logic [prmt_pkg::STATUS_W-1:0] status;
  logic                          last;

  modport source (output valid, is_request, request_kind, first_page, page_count, status,
                  last, input ready);
  modport sink   (input valid, is_request, request_kind, first_page, page_count, status,
                  last, output ready);
endinterface

/* rtl/core/prmt_front.sv */
// Front end of the tracker: takes requests, holds the region base register,
// and turns each request into a page-range command or a rejection. Depends on prmt_pkg, prmt_if.
module prmt_front #(
  parameter int PAGE_COUNT     = prmt_pkg::PAGE_COUNT_DEF,
  parameter int MAX_SPAN_PAGES = prmt_pkg::MAX_SPAN_PAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  prmt_req_if.sink                    req_i,
  input  logic                        cfg_we_i,
  input  logic [prmt_pkg::ADDR_W-1:0] cfg_wdata_i,
  input  logic                        clear_busy_i,
  output logic                        cmd_valid_o,
  output logic [2*$clog2(PAGE_COUNT)+1:0] cmd_data_o,
  input  logic                        cmd_ready_i
);

  localparam int PW   = $clog2(PAGE_COUNT);
  // Page index width of a full 33-bit byte offset
  localparam int PG_W = prmt_pkg::ADDR_W + 1 - prmt_pkg::PAGE_SHIFT;

  typedef struct packed {
    logic          reject;
    logic          kind;
    logic [PW-1:0] start;
    logic [PW-1:0] last_page;
  } cmd_t;

  logic [prmt_pkg::ADDR_W-1:0] base_q;

  logic                        s1_valid_q;
  logic                        s1_kind_q;
  logic [prmt_pkg::ADDR_W-1:0] s1_addr_q;
  logic [prmt_pkg::LEN_W-1:0]  s1_len_q;

  logic                        s2_valid_q;
  logic                        s2_kind_q;
  logic                        s2_below_q;
  logic [prmt_pkg::ADDR_W-1:0] s2_off_q;
  logic [prmt_pkg::LEN_W-1:0]  s2_len_q;

  logic                        s1_free;
  logic                        s2_free;
  logic                        s1_adv;
  logic [prmt_pkg::ADDR_W:0]   diff;
  logic [prmt_pkg::ADDR_W:0]   sum;
  logic [PG_W-1:0]             end_pg;
  logic [PG_W-1:0]             start_pg;
  cmd_t                        cmd;

  // Stall chain of the two front stages
  assign s2_free = !s2_valid_q || cmd_ready_i;
  assign s1_free = !s1_valid_q || s2_free;
  assign s1_adv  = s1_valid_q && s2_free;

  assign req_i.ready = s1_free && !clear_busy_i;

  // Region base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= prmt_pkg::BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Stage one: capture the request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= req_i.valid && req_i.ready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_kind_q <= req_i.req_type;
      s1_addr_q <= req_i.address;
      s1_len_q  <= req_i.byte_length;
    end
  end

  // Stage two: offset from the region base, with the borrow as the below-base flag.
  assign diff = {1'b0, s1_addr_q} - {1'b0, base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_kind_q  <= s1_kind_q;
      s2_below_q <= diff[prmt_pkg::ADDR_W];
      s2_off_q   <= diff[prmt_pkg::ADDR_W-1:0];
      s2_len_q   <= s1_len_q;
    end
  end

  // Page range and range checks feed the command queue directly.
  assign sum      = {1'b0, s2_off_q} +
                    {{(prmt_pkg::ADDR_W + 1 - prmt_pkg::LEN_W){1'b0}}, s2_len_q};
  assign end_pg   = sum[prmt_pkg::ADDR_W:prmt_pkg::PAGE_SHIFT];
  assign start_pg = {1'b0, s2_off_q[prmt_pkg::ADDR_W-1:prmt_pkg::PAGE_SHIFT]};

  always_comb begin
    cmd.reject    = s2_below_q ||
                    (end_pg >= PG_W'(PAGE_COUNT)) ||
                    ((end_pg - start_pg) >= PG_W'(MAX_SPAN_PAGES));
    cmd.kind      = s2_kind_q;
    cmd.start     = start_pg[PW-1:0];
    cmd.last_page = end_pg[PW-1:0];
  end

  assign cmd_valid_o = s2_valid_q;
  assign cmd_data_o  = cmd;

endmodule

/* rtl/core/prmt_cmd_fifo.sv */
// Small command queue between the front end and the counter walker.
// Valid/ready on both sides. Depends on nothing but its parameters.
module prmt_cmd_fifo #(
  parameter int DATA_W = 26,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output logic [DATA_W-1:0] pop_data_o,
  input  logic              pop_ready_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/prmt_back.sv */
// Back end of the tracker: the reference-count memory and the page walker
// that updates counts, forms map/unmap runs and drives the result register. Depends on prmt_pkg, prmt_if.
module prmt_back #(
  parameter int PAGE_COUNT = prmt_pkg::PAGE_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  logic [2*$clog2(PAGE_COUNT)+1:0] cmd_data_i,
  output logic                            cmd_ready_o,
  output logic                            clear_busy_o,
  prmt_rsp_if.source                      rsp_o
);

  localparam int PW = $clog2(PAGE_COUNT);

  typedef struct packed {
    logic          reject;
    logic          kind;
    logic [PW-1:0] start;
    logic [PW-1:0] last_page;
  } cmd_t;

  // Walker states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [prmt_pkg::CNT_W-1:0] mem [PAGE_COUNT];
  logic [prmt_pkg::CNT_W-1:0] rd_q;

  logic [2:0]                    state_q, state_d;
  logic [PW-1:0]                 cur_q, cur_d;
  logic [PW-1:0]                 last_q, last_d;
  logic                          kind_q, kind_d;
  logic [PW-1:0]                 run_start_q, run_start_d;
  logic [prmt_pkg::RUN_W-1:0]    run_len_q, run_len_d;
  logic [prmt_pkg::STATUS_W-1:0] stat_q, stat_d;
  logic                          out_valid_q, out_valid_d;
  prmt_pkg::rsp_item_t           out_q, out_d;

  cmd_t                       cmd;
  logic                       slot_free;
  logic                       mem_we;
  logic [PW-1:0]              mem_waddr;
  logic [prmt_pkg::CNT_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [PW-1:0]              mem_raddr;
  logic                       emit;
  prmt_pkg::rsp_item_t        emit_item;
  prmt_pkg::rsp_item_t        run_item;
  prmt_pkg::rsp_item_t        status_item;
  logic                       in_run;
  logic                       closing;
  logic                       saturated;
  logic [PW+prmt_pkg::FIRST_W-1:0] run_start_wide;

  assign cmd          = cmd_t'(cmd_data_i);
  assign slot_free    = !out_valid_q || rsp_o.ready;
  assign clear_busy_o = state_q == S_CLEAR;

  // Result items built from the open run and the running status
  assign run_start_wide = {{prmt_pkg::FIRST_W{1'b0}}, run_start_q};

  always_comb begin
    run_item              = '0;
    run_item.is_request   = 1'b1;
    run_item.request_kind = kind_q;
    run_item.first_page   = run_start_wide[prmt_pkg::FIRST_W-1:0];
    run_item.page_count   = run_len_q;
    run_item.status       = prmt_pkg::ST_OK;
    status_item           = '0;
    status_item.status    = stat_q;
    status_item.last      = 1'b1;
  end

  // Classification of the page whose count sits in the read register
  always_comb begin
    saturated = (kind_q == prmt_pkg::REQ_USE) && (rd_q == prmt_pkg::CNT_MAX);
    in_run    = (kind_q == prmt_pkg::REQ_USE) ? (rd_q == '0)
                                              : (rd_q == prmt_pkg::CNT_W'(1));
    closing   = !in_run && (run_len_q != '0);
  end

  // Walker: one page per cycle unless a run waits for the result slot; next page read overlaps this write
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    last_d      = last_q;
    kind_d      = kind_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    stat_d      = stat_q;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cur_q;
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    emit_item   = run_item;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cur_q == PW'(PAGE_COUNT - 1)) begin
          cur_d   = '0;
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + PW'(1);
        end
      end

      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          kind_d    = cmd.kind;
          cur_d     = cmd.start;
          last_d    = cmd.last_page;
          run_len_d = '0;
          if (cmd.reject) begin
            stat_d  = prmt_pkg::ST_REJECT;
            state_d = S_DONE;
          end else begin
            stat_d    = prmt_pkg::ST_OK;
            mem_re    = 1'b1;
            mem_raddr = cmd.start;
            state_d   = S_WALK;
          end
        end
      end

      S_WALK: begin
        if ((kind_q == prmt_pkg::REQ_RELEASE) && (rd_q == '0)) begin
          // Release of an unused page ends the walk without touching it.
          stat_d  = prmt_pkg::ST_UNUSED;
          state_d = S_FLUSH;
        end else if (!closing || slot_free) begin
          emit      = closing;
          mem_we    = !saturated;
          mem_wdata = (kind_q == prmt_pkg::REQ_USE) ? rd_q + prmt_pkg::CNT_W'(1)
                                                    : rd_q - prmt_pkg::CNT_W'(1);
          if (saturated) begin
            stat_d = prmt_pkg::ST_SAT;
          end
          if (in_run) begin
            if (run_len_q == '0) begin
              run_start_d = cur_q;
            end
            run_len_d = run_len_q + prmt_pkg::RUN_W'(1);
          end else begin
            run_len_d = '0;
          end
          if (cur_q == last_q) begin
            state_d = S_FLUSH;
          end else begin
            cur_d     = cur_q + PW'(1);
            mem_re    = 1'b1;
            mem_raddr = cur_q + PW'(1);
          end
        end
      end

      S_FLUSH: begin
        if (run_len_q == '0) begin
          state_d = S_DONE;
        end else if (slot_free) begin
          emit      = 1'b1;
          run_len_d = '0;
          state_d   = S_DONE;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_item = status_item;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cur_q       <= '0;
      run_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      run_len_q   <= run_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    kind_q      <= kind_d;
    run_start_q <= run_start_d;
    stat_q      <= stat_d;
    out_q       <= out_d;
  end

  // Reference-count memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.is_request   = out_q.is_request;
  assign rsp_o.request_kind = out_q.request_kind;
  assign rsp_o.first_page   = out_q.first_page;
  assign rsp_o.page_count   = out_q.page_count;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.last         = out_q.last;

endmodule

/* rtl/core/page_refcount_map_tracker_unit.sv */
// Top level of the page reference-count tracker: front end, command queue and page walker.
// Depends on prmt_pkg, prmt_if, prmt_front, prmt_cmd_fifo and prmt_back.
//
// The block keeps a 16-bit reference count for each 4 KiB page of a region that starts at the
// region base register, answers each use or release request with map or unmap runs followed by
// one status item marked last, and rejects requests outside the region or longer than
// MAX_SPAN_PAGES pages. After reset a clearing pass over all PAGE_COUNT pages zeroes the count
// memory and no request is taken during it; the base register can be written at any time the
// block is idle. A request passes the front capture and offset stages, and up to two more wait in
// the command queue while the walker works. The walker does a read-modify-write of one count
// per cycle on the count memory (one write port, one registered read port); a stalled result
// output holds the walker only when a new item must be handed over.
module page_refcount_map_tracker_unit #(
  parameter int PAGE_COUNT     = prmt_pkg::PAGE_COUNT_DEF,
  parameter int MAX_SPAN_PAGES = prmt_pkg::MAX_SPAN_PAGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  prmt_req_if.sink                    req_i,
  prmt_rsp_if.source                  rsp_o,
  input  logic                        cfg_we_i,
  input  logic [prmt_pkg::ADDR_W-1:0] cfg_wdata_i
);

  localparam int CMD_W = 2 * $clog2(PAGE_COUNT) + 2;

  logic             push_valid;
  logic [CMD_W-1:0] push_data;
  logic             push_ready;
  logic             pop_valid;
  logic [CMD_W-1:0] pop_data;
  logic             pop_ready;
  logic             clear_busy;

  // Request intake and range checks
  prmt_front #(
    .PAGE_COUNT    (PAGE_COUNT),
    .MAX_SPAN_PAGES(MAX_SPAN_PAGES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .clear_busy_i(clear_busy),
    .cmd_valid_o (push_valid),
    .cmd_data_o  (push_data),
    .cmd_ready_i (push_ready)
  );

  // Commands waiting for the walker
  prmt_cmd_fifo #(
    .DATA_W(CMD_W),
    .DEPTH (prmt_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .pop_ready_i (pop_ready)
  );

  // Count memory and page walker
  prmt_back #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_data_i  (pop_data),
    .cmd_ready_o (pop_ready),
    .clear_busy_o(clear_busy),
    .rsp_o       (rsp_o)
  );

endmodule

/* rtl/core/prmt_checker.sv */
// Port-level checks of the page reference-count tracker, bound to its top level.
// Depends on prmt_pkg and page_refcount_map_tracker_unit.
module prmt_checker #(
  parameter int MAX_SPAN_PAGES = prmt_pkg::MAX_SPAN_PAGES_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic                          is_request_i,
  input logic                          request_kind_i,
  input logic [prmt_pkg::FIRST_W-1:0]  first_page_i,
  input logic [prmt_pkg::RUN_W-1:0]    page_count_i,
  input logic [prmt_pkg::STATUS_W-1:0] status_i,
  input logic                          last_i
);

  // A result waiting on the sink holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({is_request_i, request_kind_i, first_page_i, page_count_i, status_i, last_i}))
    else $error("result changed while stalled");

  // The status item closes a request and carries no run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !is_request_i |-> last_i && !request_kind_i &&
      (first_page_i == '0) && (page_count_i == '0))
    else $error("malformed status item");

  // A run is never the last transfer and always reports status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && is_request_i |-> !last_i && (status_i == prmt_pkg::ST_OK) &&
      (page_count_i != '0))
    else $error("malformed run item");

  // A run never covers more pages than one request may span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && is_request_i |-> page_count_i <= prmt_pkg::RUN_W'(MAX_SPAN_PAGES))
    else $error("run longer than the span limit");

endmodule

bind page_refcount_map_tracker_unit prmt_checker #(
  .MAX_SPAN_PAGES(MAX_SPAN_PAGES)
) u_prmt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .is_request_i  (rsp_o.is_request),
  .request_kind_i(rsp_o.request_kind),
  .first_page_i  (rsp_o.first_page),
  .page_count_i  (rsp_o.page_count),
  .status_i      (rsp_o.status),
  .last_i        (rsp_o.last)
);

/* tb/page_refcount_map_tracker_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench for the page reference-count tracker: directed, dense-run and random traffic,
// checked item by item against a model of the per-page counts and the map/unmap runs.
// Depends on prmt_pkg, the prmt_req_if / prmt_rsp_if interfaces and the tracker RTL.
module page_refcount_map_tracker_unit_tb;

  localparam int     ADDR_W         = prmt_pkg::ADDR_W;
  localparam int     LEN_W          = prmt_pkg::LEN_W;
  localparam int     FIRST_W        = prmt_pkg::FIRST_W;
  localparam int     RUN_W          = prmt_pkg::RUN_W;
  localparam int     STATUS_W       = prmt_pkg::STATUS_W;
  localparam int     CNT_W          = prmt_pkg::CNT_W;
  localparam int     PAGE_SHIFT     = prmt_pkg::PAGE_SHIFT;
  localparam int     NPAGES         = prmt_pkg::PAGE_COUNT_DEF;
  localparam int     SPAN_MAX       = prmt_pkg::MAX_SPAN_PAGES_DEF;
  localparam int     PAGE_BYTES     = 1 << PAGE_SHIFT;
  localparam int     TAIL_CYCLES    = 40;
  localparam int     SQUEEZE_CYCLES = 600;
  localparam longint CYCLE_LIMIT    = 5_000_000;

  // Holds the page counts and the base, predicts the result items of each accepted
  // request and checks every result transfer against the oldest one still due.
  class page_run_scoreboard;
    logic [CNT_W-1:0]    refcnt [NPAGES];
    logic [ADDR_W-1:0]   base;
    prmt_pkg::rsp_item_t runs_due [$];
    int errors, checked, map_runs, unmap_runs, n_sat, n_unused, n_reject, most_items;

    function new();
      foreach (refcnt[i]) refcnt[i] = '0;
      base = prmt_pkg::BASE_RESET;
    endfunction

    function prmt_pkg::rsp_item_t pack_item(logic isreq, logic kind,
                                            logic [FIRST_W-1:0] first,
                                            logic [RUN_W-1:0] n, logic [STATUS_W-1:0] st,
                                            logic lst);
      prmt_pkg::rsp_item_t it;
      it.is_request   = isreq;
      it.request_kind = kind;
      it.first_page   = first;
      it.page_count   = n;
      it.status       = st;
      it.last         = lst;
      return it;
    endfunction

    function void push_run(logic kind, longint unsigned at, longint unsigned n);
      runs_due.push_back(pack_item(1'b1, kind, at[FIRST_W-1:0], n[RUN_W-1:0],
                                   prmt_pkg::ST_OK, 1'b0));
      if (kind == prmt_pkg::REQ_USE) map_runs++;
      else unmap_runs++;
    endfunction

    // Walk the covered pages the way the block does and queue the runs plus the status item.
    function void predict_runs(logic rtype, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] blen);
      longint unsigned off, pg_lo, pg_hi, pg, run_at, run_n;
      logic [CNT_W-1:0]    c;
      logic [STATUS_W-1:0] st;
      logic                hit, reject;
      int                  n0;
      n0     = runs_due.size();
      reject = (addr < base);
      if (!reject) begin
        off    = 64'(addr) - 64'(base);
        pg_lo  = off >> PAGE_SHIFT;
        pg_hi  = (off + 64'(blen)) >> PAGE_SHIFT;
        reject = (pg_hi >= 64'(NPAGES)) || (pg_hi - pg_lo + 64'(1) > 64'(SPAN_MAX));
      end
      if (reject) begin
        n_reject++;
        runs_due.push_back(pack_item(1'b0, 1'b0, '0, '0, prmt_pkg::ST_REJECT, 1'b1));
        return;
      end
      st     = prmt_pkg::ST_OK;
      run_at = 0;
      run_n  = 0;
      for (pg = pg_lo; pg <= pg_hi; pg++) begin
        c = refcnt[pg];
        if (rtype == prmt_pkg::REQ_USE) begin
          hit = (c == '0);
          if (c == prmt_pkg::CNT_MAX) st = prmt_pkg::ST_SAT;
          else refcnt[pg] = c + CNT_W'(1);
        end else begin
          // Releasing a page nobody holds ends the walk right there.
          if (c == '0) begin
            st = prmt_pkg::ST_UNUSED;
            break;
          end
          refcnt[pg] = c - CNT_W'(1);
          hit = (c == CNT_W'(1));
        end
        if (hit) begin
          if (run_n == 0) run_at = pg;
          run_n++;
        end else if (run_n != 0) begin
          push_run(rtype, run_at, run_n);
          run_n = 0;
        end
      end
      if (run_n != 0) push_run(rtype, run_at, run_n);
      if (st == prmt_pkg::ST_SAT) n_sat++;
      if (st == prmt_pkg::ST_UNUSED) n_unused++;
      runs_due.push_back(pack_item(1'b0, 1'b0, '0, '0, st, 1'b1));
      if (runs_due.size() - n0 > most_items) most_items = runs_due.size() - n0;
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_run_item(prmt_pkg::rsp_item_t got);
      prmt_pkg::rsp_item_t want;
      checked++;
      if (runs_due.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result with nothing due, expected none, actual %h", $time, got);
        return;
      end
      want = runs_due.pop_front();
      compare("is_request", 16'(want.is_request), 16'(got.is_request));
      compare("request_kind", 16'(want.request_kind), 16'(got.request_kind));
      compare("first_page", 16'(want.first_page), 16'(got.first_page));
      compare("page_count", 16'(want.page_count), 16'(got.page_count));
      compare("status", 16'(want.status), 16'(got.status));
      compare("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  typedef struct packed {
    logic [ADDR_W-1:0] off;
    logic [LEN_W-1:0]  blen;
  } span_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [ADDR_W-1:0] cfg_wdata_i;

  page_run_scoreboard board;
  span_t              held [$];
  logic               squeeze;
  logic               squeeze_done;
  logic               full_speed;
  int                 burst_left;
  int                 items_sent;
  longint             cycles = 0;

  prmt_req_if req_ch ();
  prmt_rsp_if rsp_ch ();

  page_refcount_map_tracker_unit #(
    .PAGE_COUNT     (NPAGES),
    .MAX_SPAN_PAGES (SPAN_MAX)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and hard stop.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results still due.", cycles,
               board.runs_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Every result transfer is checked against the oldest expected item.
  always @(posedge clk_i) begin : result_monitor
    prmt_pkg::rsp_item_t got;
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got.is_request   = rsp_ch.is_request;
      got.request_kind = rsp_ch.request_kind;
      got.first_page   = rsp_ch.first_page;
      got.page_count   = rsp_ch.page_count;
      got.status       = rsp_ch.status;
      got.last         = rsp_ch.last;
      board.check_run_item(got);
    end
  end

  // Result side: stall rate changes in epochs; one long hold-off when asked for.
  initial begin : result_sink
    int pct, epoch;
    pct          = 0;
    epoch        = 0;
    squeeze_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze && !squeeze_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeeze_done = 1'b1;
      end
      if (epoch == 0) begin
        epoch = $urandom_range(16, 160);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 85;
        endcase
      end
      epoch--;
      rsp_ch.ready <= full_speed || ($urandom_range(0, 99) >= pct);
    end
  end

  // Offer one request until its transfer, then update the model and maybe pause.
  task automatic send_req(logic rtype, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] blen);
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rtype;
    req_ch.address     <= addr;
    req_ch.byte_length <= blen;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
    board.predict_runs(rtype, addr, blen);
    items_sent++;
    if (!full_speed && !(squeeze && !squeeze_done)) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 8);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 7);
      end
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.runs_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base(logic [ADDR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.base = value;
    cfg_we_i <= 1'b0;
  endtask

  // Short directed list at the reset base: single pages, split runs and range edges.
  task automatic directed_items();
    logic [ADDR_W-1:0] b;
    b = board.base;
    send_req(prmt_pkg::REQ_USE, b, '0);
    send_req(prmt_pkg::REQ_USE, b + ADDR_W'(PAGE_BYTES - 1), '0);
    send_req(prmt_pkg::REQ_RELEASE, b, '0);
    send_req(prmt_pkg::REQ_RELEASE, b + ADDR_W'(12), '0);
    send_req(prmt_pkg::REQ_RELEASE, b, '0);
    send_req(prmt_pkg::REQ_USE, b + ADDR_W'(3 * PAGE_BYTES), LEN_W'(2 * PAGE_BYTES));
    // Pages 1..7 around the held 3..5: two map runs, then two unmap runs.
    send_req(prmt_pkg::REQ_USE, b + ADDR_W'(PAGE_BYTES), LEN_W'(7 * PAGE_BYTES - 1));
    send_req(prmt_pkg::REQ_RELEASE, b + ADDR_W'(PAGE_BYTES), LEN_W'(7 * PAGE_BYTES - 1));
    // The walk stops on page 6 and run 3..5 is still emitted.
    send_req(prmt_pkg::REQ_RELEASE, b + ADDR_W'(3 * PAGE_BYTES), LEN_W'(4 * PAGE_BYTES));
    send_req(prmt_pkg::REQ_USE, b - ADDR_W'(1), '0);
    send_req(prmt_pkg::REQ_RELEASE, '0, '0);
    send_req(prmt_pkg::REQ_USE, {ADDR_W{1'b1}}, {LEN_W{1'b1}});
    send_req(prmt_pkg::REQ_USE, b + ADDR_W'(16 * PAGE_BYTES),
             LEN_W'((SPAN_MAX - 1) * PAGE_BYTES));
    send_req(prmt_pkg::REQ_RELEASE, b + ADDR_W'(16 * PAGE_BYTES),
             LEN_W'((SPAN_MAX - 1) * PAGE_BYTES));
    send_req(prmt_pkg::REQ_USE, b + ADDR_W'(16 * PAGE_BYTES), LEN_W'(SPAN_MAX * PAGE_BYTES));
    send_req(prmt_pkg::REQ_USE, b + ADDR_W'((NPAGES - 1) * PAGE_BYTES),
             LEN_W'(PAGE_BYTES - 1));
    send_req(prmt_pkg::REQ_RELEASE, b + ADDR_W'((NPAGES - 1) * PAGE_BYTES + 5), '0);
    send_req(prmt_pkg::REQ_USE, b + ADDR_W'((NPAGES - 1) * PAGE_BYTES), LEN_W'(PAGE_BYTES));
  endtask

  // Every other page held, then one full-span use and release: the most runs per request.
  // The whole pattern runs back to back with the result side always ready.
  task automatic comb_pattern();
    int p0, odd;
    p0         = $urandom_range(200, NPAGES - 400);
    odd        = $urandom_range(0, 1);
    full_speed = 1'b1;
    for (int k = 0; k < SPAN_MAX / 2; k++)
      send_req(prmt_pkg::REQ_USE, board.base + ADDR_W'((p0 + 2 * k + odd) * PAGE_BYTES +
               $urandom_range(0, PAGE_BYTES - 1)), '0);
    send_req(prmt_pkg::REQ_USE, board.base + ADDR_W'(p0 * PAGE_BYTES),
             LEN_W'((SPAN_MAX - 1) * PAGE_BYTES));
    send_req(prmt_pkg::REQ_RELEASE, board.base + ADDR_W'(p0 * PAGE_BYTES +
             $urandom_range(0, PAGE_BYTES - 1)), LEN_W'((SPAN_MAX - 1) * PAGE_BYTES));
    for (int k = 0; k < SPAN_MAX / 2; k++)
      send_req(prmt_pkg::REQ_RELEASE,
               board.base + ADDR_W'((p0 + 2 * k + odd) * PAGE_BYTES), '0);
    full_speed = 1'b0;
  endtask

  // One random request: mostly use/release pairs on real pages, some edges and noise.
  task automatic random_item();
    span_t s;
    logic  rt;
    int    pick, pg, span, lo, r;
    pick = $urandom_range(0, 99);
    rt   = 1'($urandom_range(0, 1));
    if (pick >= 45 && pick < 75 && held.size() != 0) begin
      // Give back a span taken earlier so counts walk down to zero again.
      r = $urandom_range(0, held.size() - 1);
      s = held[r];
      held.delete(r);
      send_req(prmt_pkg::REQ_RELEASE, board.base + s.off, s.blen);
    end else if (pick < 83) begin
      // A span that starts inside the region, mostly short and mostly on a crowded window.
      case ($urandom_range(0, 9)) inside
        [0:5]:   pg = $urandom_range(0, 47);
        [6:7]:   pg = $urandom_range(0, NPAGES - 1);
        8:       pg = $urandom_range(NPAGES - 96, NPAGES - 1);
        default: pg = $urandom_range(0, 15);
      endcase
      span   = ($urandom_range(0, 7) == 0) ? $urandom_range(7, SPAN_MAX)
                                           : $urandom_range(1, 6);
      r      = $urandom_range(0, PAGE_BYTES - 1);
      s.off  = ADDR_W'(pg * PAGE_BYTES + r);
      s.blen = LEN_W'((span - 1) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1 - r));
      if (pick < 75) begin
        send_req(prmt_pkg::REQ_USE, board.base + s.off, s.blen);
        if (held.size() < 256) held.push_back(s);
      end else begin
        send_req(prmt_pkg::REQ_RELEASE, board.base + s.off, s.blen);
      end
    end else if (pick < 91) begin
      // Requests right at the edges of the accepted range.
      case ($urandom_range(0, 4))
        0: send_req(rt, board.base - ADDR_W'(1), LEN_W'($urandom()));
        1: begin
          pg = NPAGES - $urandom_range(0, 1);
          lo = pg - $urandom_range(0, 5);
          send_req(rt, board.base + ADDR_W'(lo * PAGE_BYTES),
                   LEN_W'((pg - lo) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1)));
        end
        2: begin
          span = SPAN_MAX + $urandom_range(0, 1);
          pg   = $urandom_range(0, NPAGES - SPAN_MAX - 2);
          r    = $urandom_range(0, PAGE_BYTES - 1);
          send_req(rt, board.base + ADDR_W'(pg * PAGE_BYTES + r),
                   LEN_W'((span - 1) * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1 - r)));
        end
        3: send_req(rt, board.base + ADDR_W'($urandom_range(0, 3 * PAGE_BYTES)),
                    {LEN_W{1'b1}});
        default: send_req(rt, {ADDR_W{1'b1}}, LEN_W'($urandom_range(0, 3 * PAGE_BYTES)));
      endcase
    end else begin
      send_req(rt, $urandom(), LEN_W'($urandom()));
    end
  endtask

  task automatic random_phase(logic [ADDR_W-1:0] value, int count);
    write_base(value);
    repeat (count) random_item();
    drain();
  endtask

  // Main sequence.
  initial begin : stimulus
    board      = new();
    squeeze    = 1'b0;
    full_speed = 1'b0;
    burst_left = 0;
    items_sent = 0;
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= 1'b0;
    req_ch.address     <= '0;
    req_ch.byte_length <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_items();
    comb_pattern();
    drain();

    // The first random phase opens with a long result stall while requests keep coming.
    squeeze = 1'b1;
    random_phase(prmt_pkg::BASE_RESET, 80);
    random_phase(32'h0000_0000, 70);
    random_phase(32'hFFFF_FFFF, 24);
    random_phase(32'hFFF8_0000, 40);
    random_phase(ADDR_W'($urandom_range(0, 32'hE000_0000)), 70);

    $display("Sent %0d requests over several region bases; %0d map and %0d unmap runs,",
             items_sent, board.map_runs, board.unmap_runs);
    $display("%0d results at most for one request; %0d saturated, %0d released unused,",
             board.most_items, board.n_sat, board.n_unused);
    $display("%0d rejected; %0d results checked, %0d errors.",
             board.n_reject, board.checked, board.errors);
    if (board.errors == 0 && board.runs_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
